@@ src/voice_activity_hangover_fsm_assert.svh @@
// Assertion macros shared by the voice activity hangover block.
`ifndef VOICE_ACTIVITY_HANGOVER_FSM_ASSERT_SVH
`define VOICE_ACTIVITY_HANGOVER_FSM_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VAHF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VAHF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/vahf_pkg.sv @@
// Types and constants of the voice activity hangover block.
package vahf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PROB_W     = 16;
    localparam int WIN_W      = 7;
    localparam int LEVEL_W    = 15;
    localparam int SUM_W      = 24;
    localparam int ACC_W      = 32;
    localparam int MEAN_W     = 16;
    localparam int KEEP_W     = ACC_W + 16;
    localparam int NEW_W      = MEAN_W + 12;
    localparam int VOICE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SUM_W-1:0]   SUM_MAX   = 24'hFF_FFFF;
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = 16'd32768;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7FFF;
    localparam logic [15:0]        COEF_KEEP = 16'd62259;
    localparam logic [11:0]        COEF_NEW  = 12'd3277;

    // voiced fraction test: count * DEN > window * NUM
    localparam logic [10:0] VOICED_NUM = 11'd9;
    localparam logic [10:0] VOICED_DEN = 11'd10;

    localparam logic [VOICE_W-1:0] VS_ENDED   = 2'd0;
    localparam logic [VOICE_W-1:0] VS_STARTED = 2'd1;
    localparam logic [VOICE_W-1:0] VS_ONGOING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE      = 3'd4;

    localparam logic [PROB_W-1:0]  RST_START_THR = 16'd31785;
    localparam logic [PROB_W-1:0]  RST_END_THR   = 16'd27853;
    localparam logic [WIN_W-1:0]   RST_HEAD      = 7'd32;
    localparam logic [WIN_W-1:0]   RST_GAP       = 7'd64;
    localparam logic [LEVEL_W-1:0] RST_GATE      = 15'd1631;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_last;
        logic [PROB_W-1:0]          speech_prob;
    } t_in_word;

    typedef struct packed {
        logic [VOICE_W-1:0] voice_state;
        logic [LEVEL_W-1:0] smoothed_level;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_EMIT
    } t_ctrl_state;

    // push a probability and scan a window back from it
    typedef struct packed {
        logic              push;
        logic [PROB_W-1:0] prob;
        logic [WIN_W-1:0]  len;
    } t_scan_req;

    typedef struct packed {
        logic             ready;
        logic             busy;
        logic [WIN_W-1:0] count;
    } t_scan_stat;

endpackage

@@ src/vahf_stream_if.sv @@
// Valid/ready stream channel carrying one word of type T.
interface vahf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ src/vahf_level.sv @@
// Frame mean by reciprocal multiply and first-order smoothing of the level.
module vahf_level #(
    parameter int FRAME_SAMPLES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vahf_pkg::SUM_W-1:0]   i_sum,
    output logic                         o_done,
    output logic [vahf_pkg::LEVEL_W-1:0] o_level
);
    import vahf_pkg::*;

    // exact floor(sum / FRAME_SAMPLES) for any 24-bit sum
    localparam int          SHIFT      = SUM_W + $clog2(FRAME_SAMPLES);
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(FRAME_SAMPLES) - 64'd1)
                                         / 64'(FRAME_SAMPLES);
    localparam int          RECIP_W    = SUM_W + 2;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int          PROD_W     = SUM_W + RECIP_W;

    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;
    logic [KEEP_W-1:0] r_keep;
    logic [NEW_W-1:0]  r_new;
    logic [ACC_W-1:0]  r_level_acc;
    logic [ACC_W-1:0]  n_level_acc;
    logic [3:0]        r_stage;
    logic [PROD_W-1:0] w_quot;
    logic [MEAN_W-1:0] w_mean;

    assign w_quot = r_prod >> SHIFT;
    assign w_mean = (w_quot > {{(PROD_W-MEAN_W){1'b0}}, MEAN_MAX}) ? MEAN_MAX
                                                                   : w_quot[MEAN_W-1:0];
    assign n_level_acc = ACC_W'(r_keep >> 16) + ACC_W'(r_new);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= i_sum;
        end
        r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
        r_keep <= KEEP_W'(r_level_acc) * KEEP_W'(COEF_KEEP);
        r_new  <= NEW_W'(w_mean) * NEW_W'(COEF_NEW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= '0;
            r_level_acc <= '0;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
            if (r_stage[2]) begin
                r_level_acc <= n_level_acc;
            end
        end
    end

    assign o_done  = r_stage[3];
    assign o_level = r_level_acc[ACC_W-1] ? LEVEL_MAX : r_level_acc[ACC_W-2:16];
endmodule

@@ src/vahf_hist.sv @@
// Probability history RAM with clearing pass and a one-read-per-cycle window scan.
module vahf_hist #(
    parameter int HISTORY = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vahf_pkg::t_scan_req         i_req,
    input  logic [vahf_pkg::PROB_W-1:0] i_thr,
    output vahf_pkg::t_scan_stat        o_stat
);
    import vahf_pkg::*;

    localparam int          AW   = $clog2(HISTORY);
    localparam logic [AW-1:0] LAST = AW'(HISTORY - 1);

    logic [PROB_W-1:0] r_mem [HISTORY];
    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_wr_idx;
    logic [AW-1:0]     r_rd_addr;
    logic [WIN_W-1:0]  r_left;
    logic              r_rd_pend;
    logic [PROB_W-1:0] r_rd_data;
    logic [WIN_W-1:0]  r_count;
    logic              r_busy;
    logic              w_issue;
    logic              w_done;
    logic [AW-1:0]     w_wr_inc;
    logic [AW-1:0]     w_clr_inc;
    logic [AW-1:0]     w_rd_dec;

    assign w_issue   = r_busy && (r_left != '0);
    assign w_done    = r_busy && (r_left == '0) && !r_rd_pend;
    assign w_wr_inc  = (r_wr_idx == LAST) ? '0 : r_wr_idx + 1'b1;
    assign w_clr_inc = (r_clr_addr == LAST) ? '0 : r_clr_addr + 1'b1;
    assign w_rd_dec  = (r_rd_addr == '0) ? LAST : r_rd_addr - 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.push) begin
            r_mem[r_wr_idx] <= i_req.prob;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_wr_idx   <= '0;
            r_rd_addr  <= '0;
            r_left     <= '0;
            r_rd_pend  <= 1'b0;
            r_count    <= '0;
            r_busy     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= w_clr_inc;
                if (r_clr_addr == LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_req.push) begin
                // scan starts at the slot just written and walks back
                r_wr_idx  <= w_wr_inc;
                r_rd_addr <= r_wr_idx;
                r_left    <= i_req.len;
                r_count   <= '0;
                r_rd_pend <= 1'b0;
                r_busy    <= 1'b1;
            end else if (r_busy) begin
                r_rd_pend <= w_issue;
                if (w_issue) begin
                    r_rd_addr <= w_rd_dec;
                    r_left    <= r_left - 1'b1;
                end
                if (r_rd_pend && (r_rd_data > i_thr)) begin
                    r_count <= r_count + 1'b1;
                end
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.ready = !r_clearing;
    assign o_stat.busy  = r_busy;
    assign o_stat.count = r_count;
endmodule

@@ src/voice_activity_hangover_fsm.sv @@
// Voice activity hangover block: takes one audio sample word per accepted input and adds its
// magnitude to a frame sum in the same cycle, so ordinary samples go at one per clock while the
// block is idle. The sample marked frame_last also carries the frame's speech probability and
// yields one result word, valid once the scan of a window of N history entries is done, where N
// is the window that the current state scans (head_frames from ended, gap_frames from ongoing
// when the probability is below the end threshold, else none), because the history sits in a RAM
// read one entry per cycle; input ready returns in the cycle that the word becomes valid. The
// mean and level path runs beside the scan, and the result also waits for it. A finished result
// waits in the output register while new samples are taken; a second frame end is taken, but its
// result and further input wait until that word is taken. After reset the history RAM is cleared
// entry by entry with input ready low; configuration writes are taken at any time.
`include "voice_activity_hangover_fsm_assert.svh"

module voice_activity_hangover_fsm #(
    parameter int HISTORY       = 128,
    parameter int FRAME_SAMPLES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vahf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vahf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vahf_stream_if.sink                     i_in,
    vahf_stream_if.source                   o_out
);
    import vahf_pkg::*;

    t_ctrl_state       r_state;
    t_ctrl_state       n_state;
    logic [PROB_W-1:0]  r_start_thr;
    logic [PROB_W-1:0]  r_end_thr;
    logic [WIN_W-1:0]   r_head;
    logic [WIN_W-1:0]   r_gap;
    logic [LEVEL_W-1:0] r_gate;
    logic [SUM_W-1:0]   r_abs_sum;
    logic [PROB_W-1:0]  r_prob;
    logic [VOICE_W-1:0] r_voice;
    logic [VOICE_W-1:0] n_voice;
    logic               r_lvl_seen;
    logic               r_out_valid;
    t_out_word          r_out_data;

    logic [SAMPLE_W-1:0] w_raw;
    logic [SAMPLE_W:0]   w_mag;
    logic [SUM_W:0]      w_sum_wide;
    logic [SUM_W-1:0]    w_sum_sat;
    logic                w_accept;
    logic                w_frame_end;
    logic                w_load;
    logic                w_head_ok;
    logic [WIN_W-1:0]    w_scan_len;
    logic                w_lvl_done;
    logic [LEVEL_W-1:0]  w_level;
    t_scan_req           w_req;
    t_scan_stat          w_scan;

    // magnitude of a signed sample; the most negative value gives 32768
    assign w_raw      = i_in.data.sample;
    assign w_mag      = w_raw[SAMPLE_W-1] ? (17'h10000 - {1'b0, w_raw}) : {1'b0, w_raw};
    assign w_sum_wide = {1'b0, r_abs_sum} + (SUM_W+1)'(w_mag);
    assign w_sum_sat  = w_sum_wide[SUM_W] ? SUM_MAX : w_sum_wide[SUM_W-1:0];

    assign i_in.ready  = (r_state == S_IDLE) && w_scan.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_frame_end = w_accept && i_in.data.frame_last;
    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    always_comb begin
        case (r_voice)
            VS_STARTED: w_scan_len = '0;
            VS_ONGOING: w_scan_len = (i_in.data.speech_prob < r_end_thr) ? r_gap : '0;
            default:    w_scan_len = r_head;
        endcase
    end

    assign w_req.push = w_frame_end;
    assign w_req.prob = i_in.data.speech_prob;
    assign w_req.len  = w_scan_len;

    vahf_hist #(
        .HISTORY(HISTORY)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_thr   (r_start_thr),
        .o_stat  (w_scan)
    );

    vahf_level #(
        .FRAME_SAMPLES(FRAME_SAMPLES)
    ) u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_frame_end),
        .i_sum   (w_sum_sat),
        .o_done  (w_lvl_done),
        .o_level (w_level)
    );

    assign w_head_ok = (11'(w_scan.count) * VOICED_DEN) > (11'(r_head) * VOICED_NUM);

    always_comb begin
        n_state = r_state;
        case (r_voice)
            VS_STARTED: n_voice = VS_ONGOING;
            VS_ONGOING: n_voice = ((r_prob < r_end_thr) && (w_scan.count == '0))
                                  ? VS_ENDED : VS_ONGOING;
            default:    n_voice = ((r_prob >= r_start_thr) && w_head_ok && (w_level > r_gate))
                                  ? VS_STARTED : VS_ENDED;
        endcase
        unique case (r_state)
            S_IDLE: begin
                if (w_frame_end) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (!w_scan.busy && r_lvl_seen) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_thr <= RST_START_THR;
            r_end_thr   <= RST_END_THR;
            r_head      <= RST_HEAD;
            r_gap       <= RST_GAP;
            r_gate      <= RST_GATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_THR: r_start_thr <= i_cfg_data;
                CFG_END_THR:   r_end_thr   <= i_cfg_data;
                CFG_HEAD:      r_head      <= i_cfg_data[WIN_W-1:0];
                CFG_GAP:       r_gap       <= i_cfg_data[WIN_W-1:0];
                CFG_GATE:      r_gate      <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_sum   <= '0;
            r_voice     <= VS_ENDED;
            r_lvl_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                // a frame end restarts the sum; its sum goes to the level path
                r_abs_sum <= i_in.data.frame_last ? '0 : w_sum_sat;
            end
            if (w_frame_end) begin
                r_lvl_seen <= 1'b0;
            end else if (w_lvl_done) begin
                r_lvl_seen <= 1'b1;
            end
            if (w_load) begin
                r_voice     <= n_voice;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_end) begin
            r_prob <= i_in.data.speech_prob;
        end
        if (w_load) begin
            r_out_data.voice_state    <= n_voice;
            r_out_data.smoothed_level <= w_level;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    `VAHF_ASSERT_NEXT(a_emit_load, w_load, r_out_valid && (r_state == S_IDLE),
                      "result word not loaded")
    `VAHF_ASSERT_NOW(a_emit_quiet, r_state == S_EMIT, !w_scan.busy && r_lvl_seen,
                     "emit before scan and level finished")
    `VAHF_ASSERT_NOW(a_start_from_end, (r_state == S_EMIT) && (n_voice == VS_STARTED),
                     (r_voice != VS_ONGOING) && (r_voice != VS_STARTED),
                     "start outside ended state")
    `VAHF_ASSERT_NEXT(a_frame_scan, w_frame_end, w_scan.busy && (r_state == S_BUSY),
                      "frame end did not launch scan")
endmodule
